// ===== sv/scrb_pkg.sv =====
// Shared types and constants for the sphere clip rectangle bounds block.
package scrb_pkg;

	// Number of steps in the square root and in the divider
	localparam int SQ_STEPS = 32;
	localparam int DIV_STEPS = 32;

	// Axis unit stages: input, squares, sum, discriminant, root steps,
	// products, D and N, partials, product sum, overflow, divide steps,
	// bound, tighten
	localparam int AXIS_STAGES = 4 + SQ_STEPS + 5 + DIV_STEPS + 2;
	// One more stage for the output register
	localparam int NUM_STAGES = AXIS_STAGES + 1;

	// Quotient magnitude cap and positive saturation value
	localparam logic [31:0] Q_CAP = 32'h8000_0000;
	localparam logic [31:0] Q_MAX = 32'h7fff_ffff;

	// Configuration register indexes
	localparam logic [1:0] CFG_SCALE_X = 2'd0;
	localparam logic [1:0] CFG_SCALE_Y = 2'd1;
	localparam logic [1:0] CFG_NEAR = 2'd2;

	typedef struct packed {
		logic signed [31:0] light_x;
		logic signed [31:0] light_y;
		logic signed [31:0] light_z;
		logic [30:0] light_radius;
	} light_t;

	typedef struct packed {
		logic signed [31:0] clip_min_x;
		logic signed [31:0] clip_min_y;
		logic signed [31:0] clip_max_x;
		logic signed [31:0] clip_max_y;
		logic in_front;
	} rect_t;

endpackage

// ===== sv/scrb_axis.sv =====
// One axis of the bounds: tangent roots, square root, scaled ratio and tighten.
module scrb_axis #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic adv,
	input logic signed [32:0] c,
	input logic signed [31:0] z,
	input logic [30:0] r,
	input logic signed [31:0] k,
	output logic signed [31:0] lo_bound,
	output logic signed [31:0] hi_bound
);
	import scrb_pkg::*;

	localparam logic signed [31:0] ONE = signed'(32'(64'd1 << FRAC_BITS));

	typedef struct packed {
		logic signed [32:0] c;
		logic signed [31:0] z;
		logic [30:0] r;
		logic ok;
	} carry_t;

	typedef struct packed {
		logic [65:0] dmag;
		logic neg;
		logic use_root;
		logic dneg;
		logic ovf;
		logic [31:0] quo;
	} div_t;

	// Stages 1 to 4
	logic signed [32:0] c_s1;
	logic signed [31:0] z_s1;
	logic [30:0] r_s1;
	logic signed [65:0] cc_full;
	logic signed [63:0] zz_full;
	logic [61:0] rr_full;
	logic [63:0] cc_s2, zz_s2, s_s3, l_s4;
	logic [61:0] rr_s2, rr_s3;
	logic signed [32:0] c_s2, c_s3;
	logic signed [31:0] z_s2, z_s3;
	logic [30:0] r_s2, r_s3;
	carry_t cr_s4;

	// Square root steps
	logic [63:0] sqx_s [1:SQ_STEPS];
	logic [63:0] sqres_s [1:SQ_STEPS];
	carry_t sqc_s [1:SQ_STEPS];

	// Products and D, N
	logic [31:0] root_mag;
	logic signed [32:0] q0;
	logic signed [64:0] qz, rc;
	logic signed [65:0] qc;
	logic signed [63:0] rz;
	logic signed [64:0] qz_s37, rc_s37;
	logic signed [65:0] qc_s37;
	logic signed [63:0] rz_s37;
	logic ok_s37, q0neg_s37, q1neg_s37;
	logic signed [66:0] d0, d1, n0, n1;
	logic signed [66:0] d_s38 [2];
	logic signed [66:0] n_s38 [2];
	logic use_s38 [2];

	// Per root bounds
	logic signed [31:0] b_s74 [2];
	logic use_s74 [2];
	logic dneg_s74 [2];
	logic signed [31:0] lo_s75, hi_s75;
	logic signed [31:0] lo_next, hi_next;

	// Register the operands
	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1 <= c;
			z_s1 <= z;
			r_s1 <= r;
		end
	end

	// Square the coordinates and the radius
	assign cc_full = c_s1 * c_s1;
	assign zz_full = z_s1 * z_s1;
	assign rr_full = r_s1 * r_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			cc_s2 <= cc_full[63:0];
			zz_s2 <= zz_full;
			rr_s2 <= rr_full;
			c_s2 <= c_s1;
			z_s2 <= z_s1;
			r_s2 <= r_s1;
		end
	end

	// Sum the squares, then form the discriminant term
	always_ff @(posedge clk) begin
		if (adv) begin
			s_s3 <= cc_s2 + zz_s2;
			rr_s3 <= rr_s2;
			c_s3 <= c_s2;
			z_s3 <= z_s2;
			r_s3 <= r_s2;
			l_s4 <= s_s3 - 64'(rr_s3);
			cr_s4.c <= c_s3;
			cr_s4.z <= z_s3;
			cr_s4.r <= r_s3;
			cr_s4.ok <= (z_s3 != 32'sd0) && (s_s3 > 64'(rr_s3));
		end
	end

	// Square root, one result bit per stage
	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
		localparam logic [63:0] BIT = 64'd1 << (2 * (SQ_STEPS - 1 - j));
		logic [63:0] x_in, res_in, trial;
		carry_t cin;
		if (j == 0) begin : g_first
			assign x_in = l_s4;
			assign res_in = '0;
			assign cin = cr_s4;
		end else begin : g_next
			assign x_in = sqx_s[j];
			assign res_in = sqres_s[j];
			assign cin = sqc_s[j];
		end
		assign trial = res_in + BIT;
		always_ff @(posedge clk) begin
			if (adv) begin
				if (x_in >= trial) begin
					sqx_s[j+1] <= x_in - trial;
					sqres_s[j+1] <= (res_in >> 1) + BIT;
				end else begin
					sqx_s[j+1] <= x_in;
					sqres_s[j+1] <= res_in >> 1;
				end
				sqc_s[j+1] <= cin;
			end
		end
	end

	// Multiply the root against depth and coordinate
	assign root_mag = sqres_s[SQ_STEPS][31:0];
	assign q0 = (sqc_s[SQ_STEPS].z > 32'sd0) ? signed'({1'b0, root_mag})
		: -signed'({1'b0, root_mag});
	assign qz = q0 * sqc_s[SQ_STEPS].z;
	assign rc = signed'({1'b0, sqc_s[SQ_STEPS].r}) * sqc_s[SQ_STEPS].c;
	assign qc = q0 * sqc_s[SQ_STEPS].c;
	assign rz = signed'({1'b0, sqc_s[SQ_STEPS].r}) * sqc_s[SQ_STEPS].z;

	always_ff @(posedge clk) begin
		if (adv) begin
			qz_s37 <= qz;
			rc_s37 <= rc;
			qc_s37 <= qc;
			rz_s37 <= rz;
			ok_s37 <= sqc_s[SQ_STEPS].ok;
			q0neg_s37 <= (sqc_s[SQ_STEPS].z < 32'sd0) && (root_mag != '0);
			q1neg_s37 <= (sqc_s[SQ_STEPS].z > 32'sd0) && (root_mag != '0);
		end
	end

	// Form divisor and numerator of both roots; keep roots in front
	assign d0 = 67'(qz_s37) + 67'(rc_s37);
	assign d1 = 67'(rc_s37) - 67'(qz_s37);
	assign n0 = 67'(qc_s37) - 67'(rz_s37);
	assign n1 = -67'(qc_s37) - 67'(rz_s37);

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s38[0] <= d0;
			d_s38[1] <= d1;
			n_s38[0] <= n0;
			n_s38[1] <= n1;
			use_s38[0] <= ok_s37 && (d0 != '0) && (d0[66] == q0neg_s37);
			use_s38[1] <= ok_s37 && (d1 != '0) && (d1[66] == q1neg_s37);
		end
	end

	for (genvar rt = 0; rt < 2; rt++) begin : g_root
		logic [66:0] dabs, nabs;
		logic [31:0] kmag;
		logic [63:0] plo;
		logic [65:0] phi;
		logic [63:0] plo_s39;
		logic [65:0] phi_s39;
		logic [65:0] dmag_s39, dmag_s40;
		logic neg_s39, use_s39, dneg_s39;
		logic neg_s40, use_s40, dneg_s40;
		logic [97:0] p_s40;
		logic [97:0] rem_s [0:DIV_STEPS];
		div_t dv_s [0:DIV_STEPS];
		logic [31:0] mag;
		logic signed [31:0] bound;

		// Take magnitudes and the two partial products of k times N
		assign dabs = d_s38[rt][66] ? 67'(-d_s38[rt]) : 67'(d_s38[rt]);
		assign nabs = n_s38[rt][66] ? 67'(-n_s38[rt]) : 67'(n_s38[rt]);
		assign kmag = k[31] ? 32'(-k) : 32'(k);
		assign plo = kmag * nabs[31:0];
		assign phi = kmag * nabs[65:32];

		always_ff @(posedge clk) begin
			if (adv) begin
				plo_s39 <= plo;
				phi_s39 <= phi;
				dmag_s39 <= dabs[65:0];
				neg_s39 <= k[31] ^ n_s38[rt][66] ^ d_s38[rt][66];
				use_s39 <= use_s38[rt];
				dneg_s39 <= d_s38[rt][66];
			end
		end

		// Sum the partial products
		always_ff @(posedge clk) begin
			if (adv) begin
				p_s40 <= {phi_s39, 32'd0} + 98'(plo_s39);
				dmag_s40 <= dmag_s39;
				neg_s40 <= neg_s39;
				use_s40 <= use_s39;
				dneg_s40 <= dneg_s39;
			end
		end

		// Flag a quotient of 2^32 or more
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[0] <= p_s40;
				dv_s[0].dmag <= dmag_s40;
				dv_s[0].neg <= neg_s40;
				dv_s[0].use_root <= use_s40;
				dv_s[0].dneg <= dneg_s40;
				dv_s[0].ovf <= p_s40 >= {dmag_s40, 32'd0};
				dv_s[0].quo <= '0;
			end
		end

		// Restoring divide, one quotient bit per stage
		for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
			logic [97:0] dsh;
			assign dsh = 98'(dv_s[i].dmag) << (DIV_STEPS - 1 - i);
			always_ff @(posedge clk) begin
				if (adv) begin
					dv_s[i+1].dmag <= dv_s[i].dmag;
					dv_s[i+1].neg <= dv_s[i].neg;
					dv_s[i+1].use_root <= dv_s[i].use_root;
					dv_s[i+1].dneg <= dv_s[i].dneg;
					dv_s[i+1].ovf <= dv_s[i].ovf;
					if (rem_s[i] >= dsh) begin
						rem_s[i+1] <= rem_s[i] - dsh;
						dv_s[i+1].quo <= {dv_s[i].quo[30:0], 1'b1};
					end else begin
						rem_s[i+1] <= rem_s[i];
						dv_s[i+1].quo <= {dv_s[i].quo[30:0], 1'b0};
					end
				end
			end
		end

		// Saturate and sign the bound
		assign mag = (dv_s[DIV_STEPS].ovf || (dv_s[DIV_STEPS].quo > Q_CAP)) ? Q_CAP
			: dv_s[DIV_STEPS].quo;
		always_comb begin
			if (mag == '0) begin
				bound = '0;
			end else if (dv_s[DIV_STEPS].neg) begin
				bound = signed'(32'(-mag));
			end else if (mag == Q_CAP) begin
				bound = signed'(Q_MAX);
			end else begin
				bound = signed'(mag);
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				b_s74[rt] <= bound;
				use_s74[rt] <= dv_s[DIV_STEPS].use_root;
				dneg_s74[rt] <= dv_s[DIV_STEPS].dneg;
			end
		end
	end

	// Tighten [-1, 1] with the roots in front
	always_comb begin
		lo_next = -ONE;
		hi_next = ONE;
		for (int i = 0; i < 2; i++) begin
			if (use_s74[i] && !dneg_s74[i] && (b_s74[i] > lo_next)) begin
				lo_next = b_s74[i];
			end
			if (use_s74[i] && dneg_s74[i] && (b_s74[i] < hi_next)) begin
				hi_next = b_s74[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lo_s75 <= lo_next;
			hi_s75 <= hi_next;
		end
	end

	assign lo_bound = lo_s75;
	assign hi_bound = hi_s75;

endmodule

// ===== sv/sphere_clip_rect_bounds_top.sv =====
// Top level of the projected sphere clip rectangle bounds pipeline.
// Takes one light sphere per cycle while light_stall is low and returns its
// clip-space bounding rectangle from a pipeline built around the 32-stage square
// root and the 32-stage restoring divider of each axis unit; with no stall on the
// result side it sustains one light per cycle. A result that meets a stall moves into a one-entry
// skid register so the pipeline advances once more; while the skid entry is full
// the whole pipeline holds and light_stall is high. Configuration writes are
// always ready and must be made while the pipeline is empty.
module sphere_clip_rect_bounds_top #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic light_valid,
	output logic light_stall,
	input scrb_pkg::light_t light,
	output logic rect_valid,
	input logic rect_stall,
	output scrb_pkg::rect_t rect,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data
);
	import scrb_pkg::*;

	localparam logic signed [31:0] ONE = signed'(32'(64'd1 << FRAC_BITS));
	localparam logic [31:0] NEAR_RESET = 32'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

	logic signed [31:0] scale_x_q, scale_y_q, near_q;
	logic adv;
	logic [NUM_STAGES:1] vld_s;
	logic [AXIS_STAGES:1] front_s;
	logic signed [32:0] zr_sum;
	logic signed [31:0] lo_x, hi_x, lo_y, hi_y;
	rect_t rect_s76;
	rect_t skid_q;
	logic skid_vld_q;

	// Write configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q <= ONE;
			scale_y_q <= ONE;
			near_q <= signed'(NEAR_RESET);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SCALE_X: scale_x_q <= signed'(cfg_data);
				CFG_SCALE_Y: scale_y_q <= signed'(cfg_data);
				CFG_NEAR: near_q <= signed'(cfg_data);
				default: ;
			endcase
		end
	end

	// Advance the pipeline unless the skid entry is full
	assign adv = !skid_vld_q;
	assign light_stall = skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NUM_STAGES-1:1], light_valid};
		end
	end

	// Near plane test, carried alongside the axis units
	assign zr_sum = 33'(light.light_z) + signed'({2'b00, light.light_radius});

	always_ff @(posedge clk) begin
		if (adv) begin
			front_s <= {front_s[AXIS_STAGES-1:1], zr_sum >= 33'(near_q)};
		end
	end

	scrb_axis #(
		.FRAC_BITS(FRAC_BITS)
	) u_axis_x (
		.clk(clk),
		.adv(adv),
		.c(33'(light.light_x)),
		.z(light.light_z),
		.r(light.light_radius),
		.k(scale_x_q),
		.lo_bound(lo_x),
		.hi_bound(hi_x)
	);

	scrb_axis #(
		.FRAC_BITS(FRAC_BITS)
	) u_axis_y (
		.clk(clk),
		.adv(adv),
		.c(-33'(light.light_y)),
		.z(light.light_z),
		.r(light.light_radius),
		.k(scale_y_q),
		.lo_bound(lo_y),
		.hi_bound(hi_y)
	);

	// Output register: drop to the empty rectangle behind the near plane
	always_ff @(posedge clk) begin
		if (adv) begin
			if (front_s[AXIS_STAGES]) begin
				rect_s76.clip_min_x <= lo_x;
				rect_s76.clip_min_y <= lo_y;
				rect_s76.clip_max_x <= hi_x;
				rect_s76.clip_max_y <= hi_y;
				rect_s76.in_front <= 1'b1;
			end else begin
				rect_s76.clip_min_x <= ONE;
				rect_s76.clip_min_y <= ONE;
				rect_s76.clip_max_x <= '0;
				rect_s76.clip_max_y <= '0;
				rect_s76.in_front <= 1'b0;
			end
		end
	end

	// Hold a stalled result in the skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (!rect_stall) begin
				skid_vld_q <= 1'b0;
			end
		end else if (vld_s[NUM_STAGES] && rect_stall) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_vld_q) begin
			skid_q <= rect_s76;
		end
	end

	assign rect_valid = skid_vld_q || vld_s[NUM_STAGES];
	assign rect = skid_vld_q ? skid_q : rect_s76;

`ifndef SYNTH
	a_empty_rect: assert property (@(posedge clk) disable iff (!arst_n)
		(rect_valid && !rect.in_front) |-> (rect.clip_min_x == ONE &&
		rect.clip_min_y == ONE && rect.clip_max_x == 32'sd0 && rect.clip_max_y == 32'sd0))
		else $error("empty rectangle malformed");
	a_front_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rect_valid && rect.in_front) |-> (rect.clip_min_x >= -ONE &&
		rect.clip_max_x <= ONE && rect.clip_min_y >= -ONE && rect.clip_max_y <= ONE))
		else $error("bound outside [-1, 1]");
	a_skid_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(vld_s[NUM_STAGES] && rect_stall))
		else $error("skid loaded without a stalled result");
`endif

endmodule

// ===== sim/sphere_clip_rect_bounds_top_tb.sv =====
// Self-checking testbench for the sphere clip rectangle bounds pipeline.
`timescale 1ns / 1ps

module sphere_clip_rect_bounds_top_tb;
	import scrb_pkg::*;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		light_t l;
		bit known;
		rect_t want;
	} row_t;

	localparam int LATENCY_WAIT = NUM_STAGES + 24;
	localparam int HANG_LIMIT = 4000;
	localparam int PHASE_ITEMS = 148;
	localparam logic signed [31:0] ONE = 32'sd65536;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic light_valid = 1'b0;
	logic light_stall;
	light_t light = '0;
	logic rect_valid;
	logic rect_stall = 1'b0;
	rect_t rect;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = CFG_SCALE_X;
	logic [31:0] cfg_data = '0;

	// Predictor copy of the configuration registers
	logic signed [31:0] scale_x_q = ONE;
	logic signed [31:0] scale_y_q = ONE;
	logic signed [31:0] near_q = 32'sd6554;

	rect_t pending_rects[$];
	row_t dir_rows[$];
	int fails = 0;
	int send_idle = 0;
	int recv_stall = 0;
	int hang_cnt = 0;
	bit progress = 1'b0;

	sphere_clip_rect_bounds_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.light_valid(light_valid),
		.light_stall(light_stall),
		.light(light),
		.rect_valid(rect_valid),
		.rect_stall(rect_stall),
		.rect(rect),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Floor square root, one result bit per pair of input bits
	function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
		logic [63:0] res;
		logic [63:0] b;
		res = '0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// k * num / den truncated toward zero, saturated to 32 bit
	function automatic logic signed [63:0] clip_ratio(input wide_t k, input wide_t num,
			input wide_t den);
		logic [127:0] m;
		logic neg;
		wide_t ak, an, ad;
		neg = (k < 0) ^ (num < 0) ^ (den < 0);
		ak = (k < 0) ? -k : k;
		an = (num < 0) ? -num : num;
		ad = (den < 0) ? -den : den;
		m = ($unsigned(ak) * $unsigned(an)) / $unsigned(ad);
		if (m == 0) return 0;
		if (neg) return (m > 128'h8000_0000) ? -64'sh8000_0000 : -$signed(m[63:0]);
		return (m >= 128'h8000_0000) ? 64'sh7fff_ffff : $signed(m[63:0]);
	endfunction

	// Tighten one axis by the two tangent planes of the sphere
	function automatic void narrow_axis(input wide_t c, input wide_t z, input wide_t r,
			input wide_t k, inout logic signed [63:0] lo, inout logic signed [63:0] hi);
		wide_t s, rr, q, den, num, rt;
		logic signed [63:0] b;
		s = c * c + z * z;
		rr = r * r;
		if (z == 0 || s <= rr) return;
		rt = {64'd0, floor_sqrt(64'(s - rr))};
		for (int root = 0; root < 2; root++) begin
			q = ((root == 0) == (z > 0)) ? rt : -rt;
			den = q * z + r * c;
			if (den == 0) continue;
			if ((den < 0) != (q < 0)) continue;
			num = q * c - r * z;
			b = clip_ratio(k, num, den);
			if (den > 0) begin
				if (b > lo) lo = b;
			end else begin
				if (b < hi) hi = b;
			end
		end
	endfunction

	function automatic rect_t project_bounds(input light_t l);
		rect_t o;
		wide_t x, y, z, r;
		logic signed [63:0] mnx, mny, mxx, mxy;
		x = l.light_x;
		y = l.light_y;
		z = l.light_z;
		r = {97'd0, l.light_radius};
		if (z + r < wide_t'(near_q)) begin
			o = '{ONE, ONE, 32'sd0, 32'sd0, 1'b0};
		end else begin
			mnx = -64'sd65536;
			mny = -64'sd65536;
			mxx = 64'sd65536;
			mxy = 64'sd65536;
			narrow_axis(x, z, r, wide_t'(scale_x_q), mnx, mxx);
			narrow_axis(-y, z, r, wide_t'(scale_y_q), mny, mxy);
			o = '{mnx[31:0], mny[31:0], mxx[31:0], mxy[31:0], 1'b1};
		end
		return o;
	endfunction

	function automatic light_t mk(input int x, input int y, input int z, input int r);
		light_t l;
		l.light_x = x;
		l.light_y = y;
		l.light_z = z;
		l.light_radius = r[30:0];
		return l;
	endfunction

	function automatic int edge_val();
		case ($urandom_range(0, 4))
			0: return 0;
			1: return 32'h7fff_ffff;
			2: return 32'h8000_0000;
			3: return 1;
			default: return -1;
		endcase
	endfunction

	// Mostly plausible scenes, some full-range noise and corner values
	function automatic light_t rand_light();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			return mk($signed($urandom_range(0, 1 << 23)) - (1 << 22),
				$signed($urandom_range(0, 1 << 23)) - (1 << 22),
				$signed($urandom_range(0, 9 << 20)) - (1 << 20),
				$urandom_range(0, 1 << 21));
		if (pick < 85)
			return mk($urandom, $urandom, $urandom, $urandom);
		return mk(edge_val(), edge_val(), edge_val(), edge_val());
	endfunction

	// Send one request, record its expected rectangle on acceptance
	task automatic send_light(input light_t l, input bit known, input rect_t want);
		bit acc;
		while ($urandom_range(0, 99) < send_idle) begin
			light_valid <= 1'b0;
			@(posedge clk);
		end
		light_valid <= 1'b1;
		light <= l;
		do begin
			@(negedge clk);
			acc = !light_stall;
			@(posedge clk);
		end while (!acc);
		pending_rects.push_back(known ? want : project_bounds(l));
	endtask

	task automatic write_cfg(input logic [1:0] idx, input logic [31:0] data);
		bit acc;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do begin
			@(negedge clk);
			acc = cfg_ready;
			@(posedge clk);
		end while (!acc);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_SCALE_X: scale_x_q = data;
			CFG_SCALE_Y: scale_y_q = data;
			CFG_NEAR: near_q = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Let the pipeline empty before touching registers or ending
	task automatic drain();
		light_valid <= 1'b0;
		while (pending_rects.size() > 0) @(posedge clk);
		repeat (LATENCY_WAIT) @(posedge clk);
	endtask

	// Randomize result-side stall
	always @(posedge clk) begin
		if (arst_n) rect_stall <= ($urandom_range(0, 99) < recv_stall);
	end

	task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
		if (e !== a) begin
			fails++;
			$display("%0t %s mismatch: expected %h actual %h", $time, name, e, a);
		end
	endtask

	// Compare each accepted result with the oldest expectation
	always @(negedge clk) begin
		rect_t e;
		progress = (light_valid && !light_stall) || (rect_valid && !rect_stall) ||
			(cfg_valid && cfg_ready);
		if (arst_n && rect_valid && !rect_stall) begin
			if (pending_rects.size() == 0) begin
				fails++;
				$display("%0t unexpected result: expected none actual %h", $time, rect);
			end else begin
				e = pending_rects.pop_front();
				check_field("clip_min_x", e.clip_min_x, rect.clip_min_x);
				check_field("clip_min_y", e.clip_min_y, rect.clip_min_y);
				check_field("clip_max_x", e.clip_max_x, rect.clip_max_x);
				check_field("clip_max_y", e.clip_max_y, rect.clip_max_y);
				check_field("in_front", 32'(e.in_front), 32'(rect.in_front));
			end
		end
	end

	// Watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (arst_n) begin
			hang_cnt <= progress ? 0 : hang_cnt + 1;
			if (hang_cnt >= HANG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		rect_t beh;
		rect_t unit;
		logic [31:0] sx[7];
		logic [31:0] sy[7];
		logic [31:0] nr[7];
		beh = '{ONE, ONE, 32'sd0, 32'sd0, 1'b0};
		unit = '{-ONE, -ONE, ONE, ONE, 1'b1};

		// Directed rows, under reset configuration
		dir_rows.push_back('{mk(0, 0, -4 * 65536, 65536), 1, beh});
		dir_rows.push_back('{mk(5, 5, 32'h8000_0000, 0), 1, beh});
		dir_rows.push_back('{mk(32'h7fff_ffff, 32'h7fff_ffff, 6553, 0), 1, beh});
		dir_rows.push_back('{mk(123, -77, 0, 65536), 1, unit});
		dir_rows.push_back('{mk(0, 0, 65536, 131072), 1, unit});
		dir_rows.push_back('{mk(1000, -1000, 6554, 0), 0, unit});
		dir_rows.push_back('{mk(65536, -65536, 65536, 65536), 0, unit});
		dir_rows.push_back('{mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff), 0, unit});
		dir_rows.push_back('{mk(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
			32'h7fff_ffff), 0, unit});
		dir_rows.push_back('{mk(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0), 0, unit});
		dir_rows.push_back('{mk(32'h7fff_ffff, 32'h8000_0000, 7000, 0), 0, unit});
		dir_rows.push_back('{mk(-5 * 65536, 3 * 65536, 2 * 65536, 65536), 0, unit});
		dir_rows.push_back('{mk(2 * 65536, -65536, 10 * 65536, 3 * 65536), 0, unit});
		dir_rows.push_back('{mk(0, 0, 3 * 65536, 65536), 0, unit});
		dir_rows.push_back('{mk(-1, 1, 1, 32'h7fff_ffff), 0, unit});

		// Register settings per random phase, extremes included
		sx = '{32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h1, 32'h0, 32'h0};
		sy = '{32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h1, 32'hffff_ffff, 32'h0, 32'h0};
		nr = '{32'h0000_199a, 32'h8000_0000, 32'h0, 32'h7fff_ffff, 32'h0001_0000, 32'h0, 32'h0};
		for (int p = 5; p < 7; p++) begin
			sx[p] = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
			sy[p] = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
			nr[p] = $urandom_range(0, 1 << 17);
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) send_light(dir_rows[i].l, dir_rows[i].known, dir_rows[i].want);
		drain();

		for (int p = 0; p < 7; p++) begin
			case (p % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 46; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 46; end
				default: begin send_idle = 12; recv_stall = 12; end
			endcase
			write_cfg(CFG_SCALE_X, sx[p]);
			write_cfg(CFG_SCALE_Y, sy[p]);
			write_cfg(CFG_NEAR, nr[p]);
			repeat (PHASE_ITEMS) send_light(rand_light(), 0, unit);
			drain();
			recv_stall = 0;
		end

		if (fails == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/scrb_pkg.sv
sv/scrb_axis.sv
sv/sphere_clip_rect_bounds_top.sv
sim/sphere_clip_rect_bounds_top_tb.sv
